// File: sv/acc_pkg.sv
// ============================================================================
// acc_pkg - shared types and constants for the analog control conditioner
// Field widths, mode codes, register map and the controller/datapath bundles.
// ============================================================================
package acc_pkg;

    // Word field widths
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 8;

    // Per-channel register field widths
    localparam int MODE_W  = 3;
    localparam int COUNT_W = 9;

    // Register widths
    localparam int MODES_W  = 18;
    localparam int INVERT_W = 6;
    localparam int COUNTS_W = 54;

    // Register port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int REG_SEL_W = 2;
    localparam logic [REG_SEL_W-1:0] REG_MODES  = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_INVERT = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_COUNTS = 2'd2;

    // Default channel count
    localparam int NUM_CHANNELS_DEF = 6;

    // Converter scale
    localparam int FULL_RANGE = 4096;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] HALF_SCALE = 12'd2048;

    // Level count limits
    localparam logic [COUNT_W-1:0] MIN_N     = 9'd2;
    localparam logic [COUNT_W-1:0] POT_MAX_N = 9'd256;
    localparam logic [COUNT_W-1:0] SEL_MAX_N = 9'd12;

    // Step lookup: one entry per level count minus one
    localparam int STEP_TAB_N = 256;

    // Restoring divide: one quotient bit per cycle
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Debounce counter
    localparam int DEB_W = 2;
    localparam logic [DEB_W-1:0] DEB_MAX = 2'd3;

    // Toggle phases
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_WAIT_PRESS  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_STABLE_PRESS = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_REL    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_STABLE_REL  = 2'd3;

    // Channel modes
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POT       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SELECTOR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOGGLE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MOMENTARY = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch incoming word
        logic prep;      // decode config, invert, look up step, seed divider
        logic div_step;  // one restoring divide iteration
        logic commit;    // update channel state, load result register
    } acc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic use_div;   // channel is quantized, needs the divider
        logic out_free;  // result register can take a word this cycle
    } acc_stat_t;

endpackage

// File: sv/acc_ctrl.sv
// ============================================================================
// acc_ctrl - sequencing controller
// Accepts one word, runs prep, the divide iterations when needed, then commit.
// ============================================================================
module acc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  acc_pkg::acc_stat_t stat,
    output acc_pkg::acc_cmd_t  cmd
);
    import acc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_EVAL = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = '0;
                state_next   = stat.use_div ? S_DIV : S_EVAL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// File: sv/acc_dp.sv
// ============================================================================
// acc_dp - conditioning datapath
// Per-channel state, step lookup, restoring divider, mode logic, result word.
// ============================================================================
module acc_dp #(
    parameter int NUM_CHANNELS = acc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  acc_pkg::acc_cmd_t             cmd,
    output acc_pkg::acc_stat_t            stat,
    input  logic [acc_pkg::CH_W-1:0]      channel,
    input  logic [acc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [acc_pkg::MODES_W-1:0]   cfg_modes,
    input  logic [acc_pkg::INVERT_W-1:0]  cfg_invert,
    input  logic [acc_pkg::COUNTS_W-1:0]  cfg_counts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [acc_pkg::CH_W-1:0]      out_channel,
    output logic [acc_pkg::LEVEL_W-1:0]   level,
    output logic                          changed
);
    import acc_pkg::*;

    localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;

    // Captured word
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] smp_reg;

    // Prepared operands
    logic [SAMPLE_W-1:0] v_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [COUNT_W-1:0]  n_reg;
    logic [SAMPLE_W-1:0] step_reg;

    // Divider
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;

    // Channel state
    logic [LEVEL_W-1:0] held_reg  [NUM_CHANNELS];
    logic [PHASE_W-1:0] phase_reg [NUM_CHANNELS];
    logic [DEB_W-1:0]   count_reg [NUM_CHANNELS];
    logic [LEVEL_W-1:0] held_next;
    logic [PHASE_W-1:0] phase_next;
    logic [DEB_W-1:0]   count_next;

    // Result register
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                changed_reg;
    logic                chg;

    // Channel index and range check
    logic [CH_EXT_W-1:0] ch_ext;
    logic [IDX_W-1:0]    idx;
    logic                in_range;

    assign ch_ext   = CH_EXT_W'(ch_reg);
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = (32'(ch_reg) < NUM_CHANNELS);

    // Step table: 4096 / (k + 1), but entry 0 holds 4096 / 2
    logic [SAMPLE_W-1:0] step_tab [STEP_TAB_N];
    for (genvar g = 0; g < STEP_TAB_N; g++)
    begin : g_step
        localparam int Div  = (g == 0) ? 2 : g + 1;
        localparam int Step = FULL_RANGE / Div;
        assign step_tab[g] = SAMPLE_W'(Step);
    end

    // Config field decode for the captured channel
    logic [63:0]         modes_ext, counts_ext;
    logic [7:0]          inv_ext;
    logic [MODE_W-1:0]   mode_now;
    logic [COUNT_W-1:0]  n_raw, n_clamp, n_m1;
    logic [SAMPLE_W-1:0] v_now;

    assign modes_ext  = 64'(cfg_modes);
    assign counts_ext = 64'(cfg_counts);
    assign inv_ext    = 8'(cfg_invert);
    assign mode_now   = MODE_W'(modes_ext >> 6'(3 * ch_reg));
    assign n_raw      = COUNT_W'(counts_ext >> 6'(9 * ch_reg));
    assign v_now      = inv_ext[ch_reg] ? (FULL_SCALE - smp_reg) : smp_reg;

    always_comb
    begin
        logic [COUNT_W-1:0] hi;
        hi = (mode_now == MODE_POT) ? POT_MAX_N : SEL_MAX_N;
        priority if (n_raw > hi)
            n_clamp = hi;
        else if (n_raw < MIN_N)
            n_clamp = MIN_N;
        else
            n_clamp = n_raw;
    end

    assign n_m1 = n_clamp - 1'b1;

    assign stat.use_div = in_range &&
                          ((mode_now == MODE_POT) || (mode_now == MODE_SELECTOR));

    // Restoring divide iteration
    always_comb
    begin
        logic [SAMPLE_W-1:0] trial;
        logic                ge;
        trial    = {rem_reg[SAMPLE_W-2:0], quo_reg[SAMPLE_W-1]};
        ge       = (trial >= step_reg);
        rem_next = ge ? (trial - step_reg) : trial;
        quo_next = {quo_reg[SAMPLE_W-2:0], ge};
    end

    // Mode logic for the selected channel
    always_comb
    begin
        logic [LEVEL_W-1:0]  held;
        logic [PHASE_W-1:0]  ph;
        logic [DEB_W-1:0]    cnt, cnt_base, cnt_up;
        logic [PHASE_W-1:0]  ph_tmp;
        logic [SAMPLE_W-1:0] pos12;
        logic [LEVEL_W-1:0]  pos, tgt;
        logic                press, rel;

        held   = held_reg[idx];
        ph     = phase_reg[idx];
        cnt    = count_reg[idx];
        press  = (v_reg < HALF_SCALE);
        rel    = (v_reg > HALF_SCALE);
        pos12  = (quo_reg >= SAMPLE_W'(n_reg)) ? SAMPLE_W'(n_reg - 1'b1) : quo_reg;
        pos    = pos12[LEVEL_W-1:0];
        tgt    = LEVEL_W'(press);
        cnt_base = cnt;
        cnt_up   = cnt;
        ph_tmp   = ph;

        held_next  = held;
        phase_next = ph;
        count_next = cnt;
        chg        = 1'b0;

        unique case (mode_reg)
            MODE_POT:
            begin
                if (pos > held)
                    chg = ((pos - held) > 8'd1) || (rem_reg > (step_reg >> 2));
                else if (pos < held)
                    chg = ((held - pos) > 8'd1) ||
                          (rem_reg < (step_reg - (step_reg >> 2)));
                if (chg)
                    held_next = pos;
            end
            MODE_SELECTOR:
            begin
                chg = (pos != held);
                if (chg)
                    held_next = pos;
            end
            MODE_TOGGLE:
            begin
                unique case (ph)
                    PH_WAIT_PRESS:
                    begin
                        if (press)
                        begin
                            phase_next = PH_STABLE_PRESS;
                            count_next = '0;
                        end
                    end
                    PH_STABLE_PRESS:
                    begin
                        if (press)
                        begin
                            cnt_up     = (cnt == DEB_MAX) ? cnt : cnt + 1'b1;
                            count_next = cnt_up;
                            if (cnt_up == DEB_MAX)
                            begin
                                held_next  = (held == '0) ? LEVEL_W'(1) : '0;
                                chg        = 1'b1;
                                phase_next = PH_WAIT_REL;
                            end
                        end
                        else
                        begin
                            phase_next = PH_WAIT_PRESS;
                        end
                    end
                    default:
                    begin
                        // wait-release runs on into the stable-release check
                        if ((ph == PH_WAIT_REL) && rel)
                        begin
                            ph_tmp   = PH_STABLE_REL;
                            cnt_base = '0;
                        end
                        if (rel)
                        begin
                            cnt_up     = (cnt_base == DEB_MAX) ? cnt_base : cnt_base + 1'b1;
                            count_next = cnt_up;
                            phase_next = (cnt_up == DEB_MAX) ? PH_WAIT_PRESS : ph_tmp;
                        end
                        else
                        begin
                            phase_next = PH_WAIT_REL;
                        end
                    end
                endcase
            end
            MODE_MOMENTARY:
            begin
                if (held == tgt)
                begin
                    count_next = '0;
                end
                else
                begin
                    cnt_up     = (cnt == DEB_MAX) ? cnt : cnt + 1'b1;
                    count_next = cnt_up;
                    if (cnt_up == DEB_MAX)
                    begin
                        held_next = tgt;
                        chg       = 1'b1;
                    end
                end
            end
            default:
            begin
                chg = 1'b0;
            end
        endcase
    end

    // Word capture, prep and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg  <= channel;
            smp_reg <= sample;
        end
        if (cmd.prep)
        begin
            v_reg    <= v_now;
            mode_reg <= mode_now;
            n_reg    <= n_clamp;
            step_reg <= step_tab[n_m1[7:0]];
            quo_reg  <= v_now;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                held_reg[i]  <= '0;
                phase_reg[i] <= PH_WAIT_PRESS;
                count_reg[i] <= '0;
            end
        end
        else if (cmd.commit && in_range)
        begin
            held_reg[idx]  <= held_next;
            phase_reg[idx] <= phase_next;
            count_reg[idx] <= count_next;
        end
    end

    // Result register
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ch_reg  <= ch_reg;
            level_reg   <= in_range ? held_next : '0;
            changed_reg <= in_range && chg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign level       = level_reg;
    assign changed     = changed_reg;

endmodule

// File: sv/analog_control_conditioner.sv
// ============================================================================
// analog_control_conditioner - per-channel knob and switch conditioning
// Pot and selector quantizing, toggle and momentary debouncing of ADC samples.
// ============================================================================
//
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  in       | in_valid, in_stall, channel, sample        | into block
//  out      | out_valid, out_stall, out_channel, level,  | out of block
//           | changed                                    |
//  regs     | psel, penable, pwrite, paddr, pwdata,      | both
//           | prdata, pready                             |
//
//  Pot and selector words run through prep, the one-bit-per-cycle restoring
//  divider and commit before the block is idle and accepts again; other
//  modes and out-of-range channels go from prep straight to commit.
//  Reset clears held levels, toggle phases, debounce counts and registers.
//  A waiting result does not block the next accept; only commit waits on
//  out_stall.
//
module analog_control_conditioner #(
    parameter int NUM_CHANNELS = acc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [acc_pkg::CH_W-1:0]      channel,
    input  logic [acc_pkg::SAMPLE_W-1:0]  sample,
    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [acc_pkg::CH_W-1:0]      out_channel,
    output logic [acc_pkg::LEVEL_W-1:0]   level,
    output logic                          changed,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acc_pkg::PADDR_W-1:0]   paddr,
    input  logic [acc_pkg::PDATA_W-1:0]   pwdata,
    output logic [acc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import acc_pkg::*;

    acc_cmd_t  cmd;
    acc_stat_t stat;

    logic [MODES_W-1:0]   modes_reg;
    logic [INVERT_W-1:0]  invert_reg;
    logic [COUNTS_W-1:0]  counts_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 reg_wr;

    // Register port
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:PADDR_W-REG_SEL_W];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg  <= '0;
            invert_reg <= '0;
            counts_reg <= '0;
        end
        else if (reg_wr)
        begin
            unique case (reg_sel)
                REG_MODES:  modes_reg  <= pwdata[MODES_W-1:0];
                REG_INVERT: invert_reg <= pwdata[INVERT_W-1:0];
                REG_COUNTS: counts_reg <= pwdata[COUNTS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODES:  prdata = PDATA_W'(modes_reg);
            REG_INVERT: prdata = PDATA_W'(invert_reg);
            REG_COUNTS: prdata = PDATA_W'(counts_reg);
            default:    prdata = '0;
        endcase
    end

    // Controller
    acc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    acc_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .channel     (channel),
        .sample      (sample),
        .cfg_modes   (modes_reg),
        .cfg_invert  (invert_reg),
        .cfg_counts  (counts_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .level       (level),
        .changed     (changed)
    );

`ifndef SYNTHESIS
    // busy after every accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // commit never overwrites a waiting result
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || !out_stall))
        else $error("commit while result register held");

    // a result appears only from a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // out-of-range channels report zero and no change
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (32'(out_channel) >= NUM_CHANNELS)) |-> (level == '0 && !changed))
        else $error("out-of-range channel reported a value");
`endif

endmodule

// File: dv/tb.sv
// ============================================================================
// tb - self-checking bench for analog_control_conditioner
// Drives channel/sample words in random bursts, stalls the result side on a
// changing pattern and predicts every result word from a per-channel model of
// the pot, selector, toggle and momentary conditioning. Registers are
// reprogrammed between phases once all results are in.
// ============================================================================
module tb;
    import acc_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;
    localparam int WORDS_PER_PHASE = 235;
    localparam int NUM_PHASES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [MODE_W-1:0] MODE_LAST_UNUSED = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
    } knob_sample_t;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] lv;
        logic               chg;
    } knob_result_t;

    // DUT connections, all inputs known from time zero
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CH_W-1:0]     channel = '0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CH_W-1:0]     out_channel;
    logic [LEVEL_W-1:0]  level;
    logic                changed;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Register copies and per-channel state of the predictor
    logic [MODES_W-1:0]  mode_reg = '0;
    logic [INVERT_W-1:0] invert_reg = '0;
    logic [COUNTS_W-1:0] count_reg = '0;
    logic [LEVEL_W-1:0]  held_lv [NUM_CH] = '{default: '0};
    logic [PHASE_W-1:0]  press_ph [NUM_CH] = '{default: '0};
    logic [DEB_W-1:0]    deb_cnt [NUM_CH] = '{default: '0};

    knob_sample_t pending_samples[$];
    knob_result_t expected_levels[$];
    int           last_smp [8] = '{default: 2048};
    int           mismatch_cnt = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_style = 0;
    int           stall_left = 0;
    int           stall_tick = 0;
    logic         in_fire = 1'b0;

    analog_control_conditioner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .level       (level),
        .changed     (changed),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Debounce counter saturates at its top value
    function automatic void bump_count(int c);
        if (deb_cnt[c] < DEB_MAX)
            deb_cnt[c] = deb_cnt[c] + 1'b1;
    endfunction

    // Predict the result word of one sample and advance channel state
    function automatic knob_result_t condition_sample(logic [CH_W-1:0] ch,
                                                      logic [SAMPLE_W-1:0] smp);
        knob_result_t r;
        logic [MODE_W-1:0] md;
        int unsigned n, lim, stp, pos, rem, v, held, t;
        int c;
        logic chg;
        c = ch;
        r.ch = ch;
        r.lv = '0;
        r.chg = 1'b0;
        if (c >= NUM_CH)
            return r;
        md = mode_reg[3*c +: MODE_W];
        n = count_reg[9*c +: COUNT_W];
        v = smp;
        if (invert_reg[c])
            v = FULL_SCALE - v;
        held = held_lv[c];
        chg = 1'b0;

        if (md == MODE_POT || md == MODE_SELECTOR)
        begin
            lim = (md == MODE_POT) ? POT_MAX_N : SEL_MAX_N;
            if (n > lim)
                n = lim;
            if (n < MIN_N)
                n = MIN_N;
            stp = FULL_RANGE / n;
            pos = v / stp;
            rem = v % stp;
            if (pos >= n)
                pos = n - 1;
            // selector follows directly, pot needs a quarter step past the edge
            if (md == MODE_SELECTOR)
                chg = (pos != held);
            else if (pos > held)
                chg = (pos - held > 1) || (rem > (stp >> 2));
            else if (pos < held)
                chg = (held - pos > 1) || (rem < stp - (stp >> 2));
            if (chg)
                held_lv[c] = pos[LEVEL_W-1:0];
        end
        else if (md == MODE_TOGGLE)
        begin
            if (press_ph[c] == PH_WAIT_PRESS)
            begin
                if (v < HALF_SCALE)
                begin
                    press_ph[c] = PH_STABLE_PRESS;
                    deb_cnt[c] = '0;
                end
            end
            else if (press_ph[c] == PH_STABLE_PRESS)
            begin
                if (v < HALF_SCALE)
                begin
                    bump_count(c);
                    if (deb_cnt[c] == DEB_MAX)
                    begin
                        held_lv[c] = (held == 0) ? 8'd1 : 8'd0;
                        chg = 1'b1;
                        press_ph[c] = PH_WAIT_REL;
                    end
                end
                else
                    press_ph[c] = PH_WAIT_PRESS;
            end
            else
            begin
                // wait-release runs straight on into the stable-release check
                if (press_ph[c] == PH_WAIT_REL && v > HALF_SCALE)
                begin
                    press_ph[c] = PH_STABLE_REL;
                    deb_cnt[c] = '0;
                end
                if (v > HALF_SCALE)
                begin
                    bump_count(c);
                    if (deb_cnt[c] == DEB_MAX)
                        press_ph[c] = PH_WAIT_PRESS;
                end
                else
                    press_ph[c] = PH_WAIT_REL;
            end
        end
        else if (md == MODE_MOMENTARY)
        begin
            t = (v < HALF_SCALE) ? 1 : 0;
            if (held == t)
                deb_cnt[c] = '0;
            else
            begin
                bump_count(c);
                if (deb_cnt[c] == DEB_MAX)
                begin
                    held_lv[c] = t[LEVEL_W-1:0];
                    chg = 1'b1;
                end
            end
        end

        r.lv = held_lv[c];
        r.chg = chg;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_cnt++;
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Word driver: bursts of words separated by random gaps
    always @(negedge clk)
    begin
        knob_sample_t w;
        logic v_next;
        v_next = in_valid && !in_fire;
        if (rst_n && !v_next)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_samples.size() > 0)
            begin
                w = pending_samples.pop_front();
                channel <= w.ch;
                sample <= w.smp;
                v_next = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 40);
                    endcase
                end
            end
        end
        in_valid <= v_next;
    end

    // Result stall: the style is redrawn whenever its random run count runs out
    always @(negedge clk)
    begin
        logic s;
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_style)
            0: s = 1'b0;
            1: s = ($urandom_range(0, 99) < 30);
            2: s = ($urandom_range(0, 99) < 75);
            default: s = ((stall_tick % 8) < 5);
        endcase
        out_stall <= s;
    end

    // Monitor: predict on accept, check on result
    always @(posedge clk)
    begin
        knob_result_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_levels.push_back(condition_sample(channel, sample));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                mismatch_cnt++;
                $display("[%0t] unexpected word: channel %0d level %0d changed %0d",
                         $time, out_channel, level, changed);
            end
            else
            begin
                want = expected_levels.pop_front();
                check_field("out_channel", want.ch, out_channel);
                check_field("level", want.lv, level);
                check_field("changed", want.chg, changed);
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_sample(int unsigned ch, int unsigned smp);
        knob_sample_t w;
        w.ch = ch[CH_W-1:0];
        w.smp = smp[SAMPLE_W-1:0];
        pending_samples.push_back(w);
    endtask

    task automatic write_reg(input logic [REG_SEL_W-1:0] idx, input logic [PDATA_W-1:0] d);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write all registers, with junk above each register's width
    task automatic program_regs(input logic [MODES_W-1:0] m, input logic [INVERT_W-1:0] inv,
                                input logic [COUNTS_W-1:0] cnt);
        logic [PDATA_W-1:0] d;
        d = {$urandom, $urandom};
        d[MODES_W-1:0] = m;
        write_reg(REG_MODES, d);
        d = {$urandom, $urandom};
        d[INVERT_W-1:0] = inv;
        write_reg(REG_INVERT, d);
        d = {$urandom, $urandom};
        d[COUNTS_W-1:0] = cnt;
        write_reg(REG_COUNTS, d);
        mode_reg = m;
        invert_reg = inv;
        count_reg = cnt;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_levels.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    // Random words, mostly runs shaped to the channel's current mode
    task automatic queue_samples(int unsigned count);
        int unsigned added, ch, n, lim, stp, run, k, smp, r;
        logic [MODE_W-1:0] md;
        int walk, span;
        logic pressed;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 99) < 4)
                ch = $urandom_range(NUM_CH, 7);
            else
                ch = $urandom_range(0, NUM_CH - 1);
            md = (ch < NUM_CH) ? mode_reg[3*ch +: MODE_W] : MODE_OFF;
            run = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0 || ch >= NUM_CH)
            begin
                add_sample(ch, $urandom_range(0, FULL_SCALE));
                run = 1;
            end
            else if (md == MODE_POT || md == MODE_SELECTOR)
            begin
                n = count_reg[9*ch +: COUNT_W];
                lim = (md == MODE_POT) ? POT_MAX_N : SEL_MAX_N;
                if (n > lim)
                    n = lim;
                if (n < MIN_N)
                    n = MIN_N;
                stp = FULL_RANGE / n;
                case ($urandom_range(0, 2))
                    0: span = 3;
                    1: span = 40;
                    default: span = 400;
                endcase
                for (int i = 0; i < run; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 3)
                    begin
                        // land right on a hysteresis edge
                        k = $urandom_range(0, n - 1);
                        case ($urandom_range(0, 3))
                            0: smp = k * stp + (stp >> 2);
                            1: smp = k * stp + (stp >> 2) + 1;
                            2: smp = k * stp + stp - (stp >> 2) - 1;
                            default: smp = k * stp + stp - (stp >> 2);
                        endcase
                        if (smp > FULL_SCALE)
                            smp = FULL_SCALE;
                    end
                    else if (r < 4)
                        smp = $urandom_range(0, FULL_SCALE);
                    else
                    begin
                        walk = last_smp[ch] + int'($urandom_range(0, 2 * span)) - span;
                        if (walk < 0)
                            walk = 0;
                        if (walk > FULL_SCALE)
                            walk = FULL_SCALE;
                        smp = walk;
                    end
                    last_smp[ch] = smp;
                    add_sample(ch, smp);
                end
            end
            else if (md == MODE_TOGGLE || md == MODE_MOMENTARY)
            begin
                pressed = $urandom_range(0, 1);
                for (int i = 0; i < run; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        smp = HALF_SCALE;
                    else if (pressed)
                        smp = $urandom_range(0, HALF_SCALE - 1);
                    else
                        smp = $urandom_range(HALF_SCALE + 1, FULL_SCALE);
                    add_sample(ch, smp);
                end
            end
            else
            begin
                add_sample(ch, $urandom_range(0, FULL_SCALE));
                run = 1;
            end
            added += run;
        end
    endtask

    initial
    begin
        logic [MODES_W-1:0]  m;
        logic [INVERT_W-1:0] inv;
        logic [COUNTS_W-1:0] cnt;
        logic [COUNT_W-1:0]  rc;
        logic [MODE_W-1:0]   rm;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // registers at reset: every channel off
        add_sample(0, FULL_SCALE);
        add_sample(3, 0);
        wait_drained();

        // directed: one channel per mode, selector inverted, count extremes
        m = {MODE_LAST_UNUSED, MODE_OFF, MODE_MOMENTARY, MODE_TOGGLE,
             MODE_SELECTOR, MODE_POT};
        inv = 6'b000010;
        cnt = {9'd0, 9'd0, 9'd0, 9'd0, SEL_MAX_N, POT_MAX_N};
        program_regs(m, inv, cnt);
        add_sample(0, 0);
        add_sample(0, FULL_SCALE);
        add_sample(0, HALF_SCALE);
        add_sample(0, HALF_SCALE - 1);
        add_sample(1, 0);
        add_sample(1, FULL_SCALE);
        // toggle: press debounce flips, mid-scale holds, release debounce
        add_sample(2, 0);
        add_sample(2, 0);
        add_sample(2, 0);
        add_sample(2, 0);
        add_sample(2, HALF_SCALE);
        add_sample(2, FULL_SCALE);
        add_sample(2, FULL_SCALE);
        add_sample(2, FULL_SCALE);
        // momentary: three disagreeing samples
        add_sample(3, 0);
        add_sample(3, 0);
        add_sample(3, 0);
        add_sample(4, FULL_SCALE);
        add_sample(5, 100);
        add_sample(6, FULL_SCALE);
        add_sample(7, 0);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                case ($urandom_range(0, 7))
                    0: rc = 0;
                    1: rc = 1;
                    2, 3: rc = $urandom_range(MIN_N, SEL_MAX_N);
                    4: rc = $urandom_range(MIN_N, POT_MAX_N);
                    5: rc = $urandom_range(SEL_MAX_N + 1, POT_MAX_N);
                    6: rc = $urandom_range(POT_MAX_N, 511);
                    default: rc = $urandom_range(0, 511);
                endcase
                case ($urandom_range(0, 9))
                    0, 1: rm = MODE_POT;
                    2, 3: rm = MODE_SELECTOR;
                    4, 5: rm = MODE_TOGGLE;
                    6, 7: rm = MODE_MOMENTARY;
                    8: rm = MODE_OFF;
                    default: rm = $urandom_range(MODE_MOMENTARY + 1, MODE_LAST_UNUSED);
                endcase
                case (ph)
                    0:
                    begin
                        m[3*c +: MODE_W] = MODE_POT;
                        cnt[9*c +: COUNT_W] = '0;
                    end
                    1:
                    begin
                        m[3*c +: MODE_W] = MODE_SELECTOR;
                        cnt[9*c +: COUNT_W] = '1;
                    end
                    2:
                    begin
                        m[3*c +: MODE_W] = MODE_TOGGLE;
                        cnt[9*c +: COUNT_W] = rc;
                    end
                    3:
                    begin
                        m[3*c +: MODE_W] = MODE_MOMENTARY;
                        cnt[9*c +: COUNT_W] = rc;
                    end
                    4:
                    begin
                        m[3*c +: MODE_W] = MODE_POT;
                        cnt[9*c +: COUNT_W] = POT_MAX_N;
                    end
                    default:
                    begin
                        m[3*c +: MODE_W] = rm;
                        cnt[9*c +: COUNT_W] = rc;
                    end
                endcase
            end
            if (ph == 0)
                inv = '1;
            else if (ph == 1)
                inv = '0;
            else
                inv = $urandom_range(0, 63);
            program_regs(m, inv, cnt);
            queue_samples(WORDS_PER_PHASE);
            wait_drained();
        end

        if (mismatch_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// File: sim.f
sv/acc_pkg.sv
sv/acc_ctrl.sv
sv/acc_dp.sv
sv/analog_control_conditioner.sv
dv/tb.sv
